// ----- hw/rtl/otq_pkg.sv -----
package otq_pkg;

  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 32;
  localparam int REF_BITS  = 8;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int IN_FIELDS_W  = REF_BITS + 3 * TIME_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = REF_BITS + 3 + TIME_BITS;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [REF_BITS-1:0]  tref;
    logic [TIME_BITS-1:0] period;
  } timer_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_POPINS
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    timer_t   entry;
  } cell_ctl_t;

  typedef struct packed {
    logic   valid;
    logic   gt;
    timer_t entry;
  } cell_link_t;

  // strict order on (expiry, id)
  function automatic logic key_lt(timer_t a, timer_t b);
    logic lt;
    if (a.expiry != b.expiry) begin
      lt = (a.expiry < b.expiry);
    end else begin
      lt = (a.tref < b.tref);
    end
    return lt;
  endfunction

endpackage

// ----- hw/rtl/otq_cell.sv -----
module otq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  otq_pkg::cell_ctl_t ctl,
  input  otq_pkg::cell_link_t from_left,
  input  otq_pkg::cell_link_t from_right,
  output otq_pkg::cell_link_t self
);
  import otq_pkg::*;

  logic   valid_r, valid_nxt;
  timer_t entry_r, entry_nxt;
  logic   gt;

  // new entry sorts before the one held here (or this cell is empty)
  assign gt = !valid_r || key_lt(ctl.entry, entry_r);

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    case (ctl.op)
      OP_INSERT: begin
        if (gt) begin
          if (from_left.gt) begin
            valid_nxt = from_left.valid;
            entry_nxt = from_left.entry;
          end else begin
            valid_nxt = 1'b1;
            entry_nxt = ctl.entry;
          end
        end
      end
      OP_POP: begin
        valid_nxt = from_right.valid;
        entry_nxt = from_right.entry;
      end
      OP_POPINS: begin
        if (from_right.gt) begin
          if (!gt) begin
            valid_nxt = 1'b1;
            entry_nxt = ctl.entry;
          end
        end else begin
          valid_nxt = from_right.valid;
          entry_nxt = from_right.entry;
        end
      end
      default: begin
        valid_nxt = valid_r;
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
  end

  assign self.valid = valid_r;
  assign self.gt    = gt;
  assign self.entry = entry_r;

endmodule

// ----- hw/rtl/otq_chain.sv -----
module otq_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  otq_pkg::cell_ctl_t  ctl,
  output otq_pkg::cell_link_t head,
  output logic                full
);
  import otq_pkg::*;

  cell_link_t links [DEPTH];
  cell_link_t edge_left;
  cell_link_t edge_right;

  assign edge_left  = '{valid: 1'b0, gt: 1'b0, entry: '0};
  assign edge_right = '{valid: 1'b0, gt: 1'b1, entry: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t left_in;
    cell_link_t right_in;
    if (i == 0) begin : g_first
      assign left_in = edge_left;
    end else begin : g_mid_l
      assign left_in = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = edge_right;
    end else begin : g_mid_r
      assign right_in = links[i+1];
    end
    otq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .from_left  (left_in),
      .from_right (right_in),
      .self       (links[i])
    );
  end

  assign head = links[0];
  assign full = links[DEPTH-1].valid;

endmodule

// ----- hw/rtl/ordered_timer_queue.sv -----
// Ordered timer queue: up to 16 timers kept sorted by (expiration, id) in a
// chain of cells, earliest at the head.
// Input beats: in_tuser selects add (0) or tick (1). An add stores a timer
// and returns one beat with earliest_changed / add_dropped. A tick removes
// every timer whose expiration is strictly below the tick time, one per cycle
// from the head; a repeating timer is put back at now + period (saturated)
// in the same cycle. Then one beat per expired timer goes out in order,
// or a single beat with expired_valid low if none expired; out_tlast marks
// the final beat of every item. All beats carry the post-item queue_empty
// and next_deadline.
// Timing: an add's result is registered. A tick scans the chain first,
// popping one expired entry per cycle from the head of the chain, then
// emits its beats as the output register is drained.
// in_tready is high when the block is idle and the output register is free
// or being drained this cycle; a stalled out_tready holds the current beat
// and the remaining results.
// Reset (rst_n low, synchronous) empties the queue and drops pending beats.
module ordered_timer_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [otq_pkg::IN_DATA_W-1:0]    in_tdata,   // timer_ref, expire_time, period, tick_time
  input  logic                             in_tuser,   // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [otq_pkg::OUT_DATA_W-1:0]   out_tdata,  // expired_ref, earliest_changed,
                                                       // add_dropped, queue_empty,
                                                       // next_deadline, zero fill
  output logic                             out_tuser,  // expired_valid
  output logic                             out_tlast
);
  import otq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic [REF_BITS-1:0]  in_ref;
  logic [TIME_BITS-1:0] in_expiry;
  logic [TIME_BITS-1:0] in_period;
  logic [TIME_BITS-1:0] in_now;

  assign in_ref    = in_tdata[REF_BITS-1:0];
  assign in_expiry = in_tdata[REF_BITS +: TIME_BITS];
  assign in_period = in_tdata[REF_BITS + TIME_BITS +: TIME_BITS];
  assign in_now    = in_tdata[REF_BITS + 2*TIME_BITS +: TIME_BITS];

  cell_ctl_t  ctl;
  cell_link_t head;
  logic       full;

  otq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (head),
    .full  (full)
  );

  logic [TIME_BITS-1:0] now_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     idx_r;
  logic [REF_BITS-1:0]  xref_r [DEPTH];

  logic                 out_valid_r;
  logic                 out_ev_r;
  logic [REF_BITS-1:0]  out_ref_r;
  logic                 out_ec_r;
  logic                 out_drop_r;
  logic                 out_empty_r;
  logic [TIME_BITS-1:0] out_dl_r;
  logic                 out_last_r;

  logic                 out_free;
  logic                 out_load;
  logic                 in_acc;
  logic                 is_add;
  logic                 add_changed;
  logic                 head_expired;
  logic [TIME_BITS:0]   resched_sum;
  logic [TIME_BITS-1:0] resched_time;
  logic                 emit_last;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign is_add    = (req_type_t'(in_tuser) == REQ_ADD);
  assign out_load  = ((state_r == ST_IDLE) && in_acc && is_add) ||
                     ((state_r == ST_EMIT) && out_free);

  assign add_changed  = (!head.valid || (in_expiry < head.entry.expiry)) && !full;
  assign head_expired = head.valid && (head.entry.expiry < now_r);
  assign resched_sum  = {1'b0, now_r} + {1'b0, head.entry.period};
  assign resched_time = resched_sum[TIME_BITS] ? '1 : resched_sum[TIME_BITS-1:0];
  assign emit_last    = (idx_r == cnt_r - CNT_W'(1));

  always_comb begin
    ctl.op    = OP_HOLD;
    ctl.entry = '{expiry: in_expiry, tref: in_ref, period: in_period};
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_add && !full) begin
          ctl.op = OP_INSERT;
        end
      end
      ST_SCAN: begin
        ctl.entry = '{expiry: resched_time, tref: head.entry.tref,
                      period: head.entry.period};
        if (head_expired) begin
          ctl.op = (head.entry.period != '0) ? OP_POPINS : OP_POP;
        end
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_add) begin
              out_ev_r    <= 1'b0;
              out_ref_r   <= '0;
              out_ec_r    <= add_changed;
              out_drop_r  <= full;
              out_empty_r <= 1'b0;
              out_dl_r    <= add_changed ? in_expiry : head.entry.expiry;
              out_last_r  <= 1'b1;
            end else begin
              now_r   <= in_now;
              cnt_r   <= '0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (head_expired) begin
            xref_r[cnt_r[IDX_W-1:0]] <= head.entry.tref;
            cnt_r                    <= cnt_r + CNT_W'(1);
          end else begin
            idx_r   <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_ec_r    <= 1'b0;
            out_drop_r  <= 1'b0;
            out_empty_r <= !head.valid;
            out_dl_r    <= head.valid ? head.entry.expiry : '0;
            if (cnt_r == '0) begin
              out_ev_r   <= 1'b0;
              out_ref_r  <= '0;
              out_last_r <= 1'b1;
              state_r    <= ST_IDLE;
            end else begin
              out_ev_r   <= 1'b1;
              out_ref_r  <= xref_r[idx_r[IDX_W-1:0]];
              out_last_r <= emit_last;
              idx_r      <= idx_r + CNT_W'(1);
              if (emit_last) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_dl_r, out_empty_r,
                       out_drop_r, out_ec_r, out_ref_r};

endmodule
